// ===== hw/rtl/rdq_pkg.sv =====
package rdq_pkg;

    localparam int unsigned DEPTH_DEF = 1024;
    localparam int unsigned DATA_W    = 32;

    // command codes
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [2:0] CMD_POP_BACK   = 3'd3;
    localparam logic [2:0] CMD_REVERSE    = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]               cmd;
        logic signed [DATA_W-1:0] push_value;
    } t_in;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] pop_value;
    } t_out;

    // per-command outcome handed from the controller to the result register
    typedef struct packed {
        logic       res_valid;
        logic [1:0] status;
        logic       pop_ok;
    } t_step;

    // memory request from the controller
    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

endpackage

// ===== hw/rtl/rdq_ram.sv =====
module rdq_ram #(
    parameter int unsigned WIDTH = rdq_pkg::DATA_W,
    parameter int unsigned DEPTH = rdq_pkg::DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/rdq_ctrl.sv =====
module rdq_ctrl #(
    parameter int unsigned DEPTH = rdq_pkg::DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic [2:0]                 i_cmd,
    output rdq_pkg::t_mem_ctl          o_mem,
    output logic [$clog2(DEPTH)-1:0]   o_waddr,
    output logic [$clog2(DEPTH)-1:0]   o_raddr,
    output rdq_pkg::t_step             o_step
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned SW = CW + 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);

    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic          r_rev, n_rev;

    logic          is_push, is_pop, at_front, full, empty;
    logic [AW-1:0] head_dec, head_inc, tail_wr, tail_rd;
    logic [SW-1:0] sum_wr, sum_rd;

    assign is_push  = (i_cmd == rdq_pkg::CMD_PUSH_FRONT) || (i_cmd == rdq_pkg::CMD_PUSH_BACK);
    assign is_pop   = (i_cmd == rdq_pkg::CMD_POP_FRONT) || (i_cmd == rdq_pkg::CMD_POP_BACK);
    assign at_front = ((i_cmd == rdq_pkg::CMD_PUSH_FRONT) ||
                       (i_cmd == rdq_pkg::CMD_POP_FRONT)) ^ r_rev;
    assign full     = (r_count == FULL_CNT);
    assign empty    = (r_count == '0);

    // wrap by one compare and subtract: every sum stays below twice the depth
    assign head_dec = (r_head == '0) ? LAST_IDX : r_head - AW'(1);
    assign head_inc = (r_head == LAST_IDX) ? '0 : r_head + AW'(1);
    assign sum_wr   = SW'(r_head) + SW'(r_count);
    assign sum_rd   = sum_wr - SW'(1);
    assign tail_wr  = (sum_wr >= DEPTH_S) ? AW'(sum_wr - DEPTH_S) : AW'(sum_wr);
    assign tail_rd  = (sum_rd >= DEPTH_S) ? AW'(sum_rd - DEPTH_S) : AW'(sum_rd);

    always_comb begin
        n_head    = r_head;
        n_count   = r_count;
        n_rev     = r_rev;
        o_mem     = '0;
        o_waddr   = at_front ? head_dec : tail_wr;
        o_raddr   = at_front ? r_head : tail_rd;
        o_step    = '0;
        if (i_accept) begin
            unique case (1'b1)
                (i_cmd == rdq_pkg::CMD_REVERSE): begin
                    n_rev = ~r_rev;
                end
                is_push: begin
                    if (full) begin
                        o_step.res_valid = 1'b1;
                        o_step.status    = rdq_pkg::ST_FULL;
                    end else begin
                        o_mem.we = 1'b1;
                        n_count  = r_count + CW'(1);
                        if (at_front) begin
                            n_head = head_dec;
                        end
                    end
                end
                is_pop: begin
                    o_step.res_valid = 1'b1;
                    if (empty) begin
                        o_step.status = rdq_pkg::ST_EMPTY;
                    end else begin
                        o_step.status = rdq_pkg::ST_OK;
                        o_step.pop_ok = 1'b1;
                        o_mem.re      = 1'b1;
                        n_count       = r_count - CW'(1);
                        if (at_front) begin
                            n_head = head_inc;
                        end
                    end
                end
                default: begin
                    // no job for this code: report empty
                    o_step.res_valid = 1'b1;
                    o_step.status    = rdq_pkg::ST_EMPTY;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_rev   <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            r_rev   <= n_rev;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= FULL_CNT) && (r_head <= LAST_IDX))
        else $error("entry count or head out of range");

    a_reverse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && (i_cmd == rdq_pkg::CMD_REVERSE)) |=>
        (r_rev != $past(r_rev)) && $stable(r_head) && $stable(r_count))
        else $error("reverse touched pointers or missed the flag");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && is_pop && !empty) |=> (r_count == $past(r_count) - CW'(1)))
        else $error("pop did not drop the count by one");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && is_push && full) |=> $stable(r_count) && $stable(r_head))
        else $error("push into a full store changed state");

endmodule

// ===== hw/rtl/reversible_deque.sv =====
// Channel   Direction  Transfer condition          Payload
// command   in         start && !busy at edge      i_item   (rdq_pkg::t_in)
// result    out        o_strobe high, one cycle    o_result (rdq_pkg::t_out)
//
// One command is taken every cycle while busy is low; its result, if any, is shown in the
// cycle after the transfer. That delay is the registered read of the entry
// memory; pointers and count update in the same cycle.
// busy is high only during reset and the cycle after it; the store is not cleared,
// its entries are undefined until pushed. The receiver cannot stall: each
// result stands for exactly one cycle.
module reversible_deque #(
    parameter int unsigned DEPTH = rdq_pkg::DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  rdq_pkg::t_in   i_item,
    output logic           o_strobe,
    output rdq_pkg::t_out  o_result
);

    localparam int unsigned AW = $clog2(DEPTH);

    logic                      accept;
    rdq_pkg::t_mem_ctl         mem_ctl;
    rdq_pkg::t_step            step;
    logic [AW-1:0]             waddr, raddr;
    logic [rdq_pkg::DATA_W-1:0] rdata;

    logic       r_busy;
    logic       r_strobe;
    logic [1:0] r_status;
    logic       r_pop_ok;

    // a command transfers when start meets a low busy
    assign accept = start && !busy;

    // pointer, count and reversal state; picks the physical end to touch
    rdq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_cmd    (i_item.cmd),
        .o_mem    (mem_ctl),
        .o_waddr  (waddr),
        .o_raddr  (raddr),
        .o_step   (step)
    );

    // entry store; a pop reads at the transfer edge, data is ready next cycle.
    // A read never meets a write of the same command, so no bypass is needed.
    rdq_ram #(
        .WIDTH (rdq_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_ctl.we),
        .i_waddr (waddr),
        .i_wdata (i_item.push_value),
        .i_re    (mem_ctl.re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // result register: hold status for one cycle, the value comes from the RAM
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b1;
            r_strobe <= 1'b0;
            r_status <= rdq_pkg::ST_OK;
            r_pop_ok <= 1'b0;
        end else begin
            r_busy   <= 1'b0;
            r_strobe <= step.res_valid;
            r_status <= step.status;
            r_pop_ok <= step.pop_ok;
        end
    end

    assign busy               = r_busy;
    assign o_strobe           = r_strobe;
    assign o_result.status    = r_status;
    // drop the RAM output to zero unless a pop really took a value
    assign o_result.pop_value = r_pop_ok ? rdata : '0;

endmodule

// ===== tb/tb_reversible_deque.sv =====
module tb_reversible_deque;

    localparam int unsigned DEPTH       = rdq_pkg::DEPTH_DEF;
    localparam int unsigned AW          = $clog2(DEPTH);
    localparam int unsigned CYCLE_LIMIT = 500000;

    // codes above reverse have no job; the block answers them with an empty status
    localparam logic [2:0] CMD_FIRST_UNUSED = rdq_pkg::CMD_REVERSE + 3'd1;
    localparam logic [2:0] CMD_LAST_CODE    = 3'b111;

    localparam logic [31:0] VAL_MIN = 32'h8000_0000;
    localparam logic [31:0] VAL_MAX = 32'h7fff_ffff;

    logic          i_clk;
    logic          i_rst_n = 1'b0;
    logic          start   = 1'b0;
    logic          busy;
    rdq_pkg::t_in  i_item  = '0;
    logic          o_strobe;
    rdq_pkg::t_out o_result;

    // mirror of the deque: circular store, head slot, fill count, reversal flag
    logic [31:0]   mirror_mem [DEPTH];
    logic [AW-1:0] mirror_head    = '0;
    logic [AW:0]   mirror_fill    = '0;
    logic          mirror_flipped = 1'b0;

    rdq_pkg::t_out pending_results [$];
    int unsigned   mismatches  = 0;
    int unsigned   cycle_count = 0;
    bit            no_idle     = 1'b0;

    reversible_deque dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL reversible_deque");
            $finish;
        end
    end

    // Append one expected result behind the older ones.
    task automatic queue_expect(input rdq_pkg::t_out res);
        pending_results = {pending_results, res};
    endtask

    // Apply one accepted command to the mirror; queue the result it causes, if any.
    task automatic apply_command(input rdq_pkg::t_in item);
        rdq_pkg::t_out res;
        logic          at_head;
        logic [AW-1:0] slot;
        res = '0;
        at_head = ((item.cmd == rdq_pkg::CMD_PUSH_FRONT) ||
                   (item.cmd == rdq_pkg::CMD_POP_FRONT)) ^ mirror_flipped;
        case (item.cmd)
            rdq_pkg::CMD_REVERSE: begin
                mirror_flipped = ~mirror_flipped;
            end
            rdq_pkg::CMD_PUSH_FRONT, rdq_pkg::CMD_PUSH_BACK: begin
                if (mirror_fill == DEPTH) begin
                    res.status = rdq_pkg::ST_FULL;
                    queue_expect(res);
                end else begin
                    if (at_head) begin
                        mirror_head = mirror_head - 1'b1;
                        slot = mirror_head;
                    end else begin
                        slot = mirror_head + AW'(mirror_fill);
                    end
                    mirror_mem[slot] = item.push_value;
                    mirror_fill++;
                end
            end
            rdq_pkg::CMD_POP_FRONT, rdq_pkg::CMD_POP_BACK: begin
                if (mirror_fill == 0) begin
                    res.status = rdq_pkg::ST_EMPTY;
                end else begin
                    if (at_head) begin
                        slot = mirror_head;
                        mirror_head = mirror_head + 1'b1;
                    end else begin
                        slot = mirror_head + AW'(mirror_fill - 1'b1);
                    end
                    res.status    = rdq_pkg::ST_OK;
                    res.pop_value = mirror_mem[slot];
                    mirror_fill--;
                end
                queue_expect(res);
            end
            default: begin
                res.status = rdq_pkg::ST_EMPTY;
                queue_expect(res);
            end
        endcase
    endtask

    // Check each result against the oldest expectation, then record this edge's transfer.
    always @(posedge i_clk) begin
        rdq_pkg::t_out want;
        if (o_strobe === 1'b1) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result status=%0d pop_value=%0d",
                         $time, o_result.status, o_result.pop_value);
                mismatches++;
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                if (o_result.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_result.status);
                    mismatches++;
                end
                if (o_result.pop_value !== want.pop_value) begin
                    $display("%0t: pop_value expected %0d actual %0d",
                             $time, want.pop_value, o_result.pop_value);
                    mismatches++;
                end
            end
        end
        if (i_rst_n && start && busy === 1'b0)
            apply_command(i_item);
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Hold start until the transfer happens, then idle for a random gap.
    task automatic send_command(input logic [2:0] cmd, input logic [31:0] value);
        int unsigned gap;
        start  <= 1'b1;
        i_item <= rdq_pkg::t_in'{cmd: cmd, push_value: value};
        do @(posedge i_clk); while (busy !== 1'b0);
        gap = pick_gap();
        if (gap != 0) begin
            start  <= 1'b0;
            i_item <= rdq_pkg::t_in'{cmd: 3'($urandom), push_value: $urandom};
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop sending and wait until every expected result has come back.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // Empty pops at both ends, unused codes, extreme values, wrap of the head,
    // and pops under reversal.
    task automatic test_directed();
        send_command(rdq_pkg::CMD_POP_FRONT, VAL_MAX);
        send_command(rdq_pkg::CMD_POP_BACK, VAL_MIN);
        send_command(CMD_FIRST_UNUSED, '1);
        send_command(CMD_FIRST_UNUSED + 3'd1, '0);
        send_command(CMD_LAST_CODE, 32'h5a5a_a5a5);
        send_command(rdq_pkg::CMD_REVERSE, '0);
        send_command(rdq_pkg::CMD_POP_FRONT, '0);
        send_command(rdq_pkg::CMD_REVERSE, '1);
        send_command(rdq_pkg::CMD_PUSH_FRONT, VAL_MAX);
        send_command(rdq_pkg::CMD_PUSH_BACK, VAL_MIN);
        send_command(rdq_pkg::CMD_PUSH_FRONT, '0);
        send_command(rdq_pkg::CMD_PUSH_BACK, '1);
        send_command(rdq_pkg::CMD_POP_BACK, '0);
        send_command(rdq_pkg::CMD_REVERSE, '0);
        send_command(rdq_pkg::CMD_POP_BACK, '0);
        send_command(rdq_pkg::CMD_PUSH_FRONT, 32'h5555_5555);
        send_command(rdq_pkg::CMD_PUSH_BACK, 32'haaaa_aaaa);
        send_command(rdq_pkg::CMD_POP_FRONT, '0);
        send_command(rdq_pkg::CMD_POP_FRONT, '0);
        send_command(rdq_pkg::CMD_REVERSE, '0);
        send_command(rdq_pkg::CMD_POP_FRONT, '0);
        send_command(rdq_pkg::CMD_POP_BACK, '0);
        send_command(rdq_pkg::CMD_POP_BACK, '0);
        send_command(rdq_pkg::CMD_POP_FRONT, '0);
    endtask

    // Fill the store to the brim, push into it while full, then pop a stretch
    // from both ends with reversals mixed in.
    task automatic test_full_and_empty();
        int unsigned room;
        drain_results();
        no_idle = 1'b1;
        room = DEPTH - mirror_fill;
        repeat (room)
            send_command($urandom_range(0, 1) ? rdq_pkg::CMD_PUSH_BACK
                                              : rdq_pkg::CMD_PUSH_FRONT, pick_value());
        send_command(rdq_pkg::CMD_PUSH_FRONT, VAL_MAX);
        send_command(rdq_pkg::CMD_PUSH_BACK, VAL_MIN);
        send_command(rdq_pkg::CMD_REVERSE, '0);
        send_command(rdq_pkg::CMD_PUSH_FRONT, '1);
        no_idle = 1'b0;
        repeat (64) begin
            if ($urandom_range(0, 15) == 0)
                send_command(rdq_pkg::CMD_REVERSE, $urandom);
            send_command($urandom_range(0, 1) ? rdq_pkg::CMD_POP_BACK
                                              : rdq_pkg::CMD_POP_FRONT, $urandom);
        end
    endtask

    // Segments of random commands, each with its own push/pop balance; some
    // segments run back to back with no idle cycles.
    task automatic test_random_traffic(input int unsigned n_items);
        int unsigned sent;
        int unsigned push_pct;
        int unsigned r;
        logic [2:0]  cmd;
        bit          paused;
        sent   = 0;
        paused = 1'b0;
        while (sent < n_items) begin
            push_pct = $urandom_range(20, 85);
            no_idle  = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(30, 90)) begin
                r = $urandom_range(0, 99);
                if (r < 5)
                    cmd = 3'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_CODE));
                else if (r < 13)
                    cmd = rdq_pkg::CMD_REVERSE;
                else if ($urandom_range(0, 99) < push_pct)
                    cmd = $urandom_range(0, 1) ? rdq_pkg::CMD_PUSH_BACK
                                               : rdq_pkg::CMD_PUSH_FRONT;
                else
                    cmd = $urandom_range(0, 1) ? rdq_pkg::CMD_POP_BACK
                                               : rdq_pkg::CMD_POP_FRONT;
                send_command(cmd, pick_value());
                sent++;
            end
            if (!paused && sent >= n_items / 2) begin
                drain_results();
                paused = 1'b1;
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_traffic(160);
        test_full_and_empty();

        // let the last result through, then a few spare cycles
        drain_results();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0)
            $display("PASS reversible_deque");
        else
            $display("FAIL reversible_deque");
        $finish;
    end

endmodule
